>>> hdl/wwkm_pkg.sv
// ----------------------------------------------------------------------------
// wwkm_pkg
// Shared types, constants and character helpers for the keyword matcher.
// ----------------------------------------------------------------------------
package wwkm_pkg;

  // Default longest pattern, in bytes
  localparam int unsigned PATTERN_MAX_DEF = 8;

  // Configuration port geometry
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned LEN_REG_W   = 4;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MATCH_MODE     = 2'd2;

  // Match modes
  localparam logic MODE_WHOLE_WORD = 1'b0;
  localparam logic MODE_SUBSTRING  = 1'b1;

  // The one non-alphanumeric word character
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

  // Classified text item passed from the front end to the matcher
  typedef struct packed {
    logic [7:0] text_byte;  // lowercased
    logic       is_word;
    logic       last_byte;
  } item_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return (c == CHAR_UNDERSCORE) ||
           (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

>>> hdl/wwkm_front.sv
// ----------------------------------------------------------------------------
// wwkm_front
// Input stage: takes text bytes, folds case, tags word characters, registers.
// ----------------------------------------------------------------------------
module wwkm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          text_byte_i,
  input  logic                last_byte_i,
  output logic                push_valid_o,
  input  logic                push_stall_i,
  output wwkm_pkg::item_t     push_item_o
);

  logic            valid_q, valid_d;
  wwkm_pkg::item_t item_q;
  logic            accept;
  logic            push;

  assign push       = valid_q && !push_stall_i;
  assign in_stall_o = valid_q && !push;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.text_byte <= wwkm_pkg::fold_case(text_byte_i);
      item_q.is_word   <= wwkm_pkg::is_word_char(text_byte_i);
      item_q.last_byte <= last_byte_i;
    end
  end

  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

endmodule

>>> hdl/wwkm_queue.sv
// ----------------------------------------------------------------------------
// wwkm_queue
// Two-entry queue decoupling the input stage from the matcher.
// ----------------------------------------------------------------------------
module wwkm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_stall_o,
  input  wwkm_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output wwkm_pkg::item_t pop_item_o
);

  wwkm_pkg::item_t slot_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            push;
  logic            pop;

  assign push_stall_o = (count_q == 2'd2);
  assign push         = push_valid_i && !push_stall_o;
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop          = pop_i && pop_valid_o;
  assign pop_item_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> hdl/wwkm_back.sv
// ----------------------------------------------------------------------------
// wwkm_back
// Matcher: sliding window, per-length comparators, word-boundary tracking
// and the registered result.
// ----------------------------------------------------------------------------
module wwkm_back #(
  parameter int unsigned PATTERN_MAX = wwkm_pkg::PATTERN_MAX_DEF,
  localparam int unsigned LW = $clog2(PATTERN_MAX + 1),
  localparam int unsigned SW = $clog2(PATTERN_MAX + 2)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                item_valid_i,
  input  wwkm_pkg::item_t                     item_i,
  output logic                                item_pop_o,
  input  logic [PATTERN_MAX-1:0][7:0]         pattern_i,
  input  logic [wwkm_pkg::LEN_REG_W-1:0]      pattern_length_i,
  input  logic                                match_mode_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                matched_o
);

  logic [PATTERN_MAX-1:0][7:0] win_q;     // newest byte at 0
  logic [PATTERN_MAX-1:0]      wword_q;   // word flags of win_q
  logic [PATTERN_MAX-1:0][7:0] win_new;
  logic [SW-1:0]               seen_q, seen_d, seen_new;
  logic                        pend_q, pend_d;
  logic                        found_q, found_d;
  logic                        out_valid_q, out_valid_d;
  logic                        matched_q, matched_d;
  logic [PATTERN_MAX:0]        hit_v;
  logic [PATTERN_MAX:0]        left_v;
  logic [LW-1:0]               len_eff;
  logic                        hit, left_open, found_step, pend_step, eq;
  logic                        out_free, pop;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign pop        = item_valid_i && (!item_i.last_byte || out_free);
  assign item_pop_o = pop;

  // Window after this byte shifts in
  always_comb begin
    win_new[0] = item_i.text_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_new[k] = win_q[k-1];
    end
  end

  assign seen_new = (seen_q == SW'(PATTERN_MAX + 1)) ? seen_q : seen_q + SW'(1);

  assign len_eff = (pattern_length_i > wwkm_pkg::LEN_REG_W'(PATTERN_MAX)) ?
                   LW'(PATTERN_MAX) : pattern_length_i[LW-1:0];

  // One comparator bank per candidate length; len_eff picks the live one
  always_comb begin
    hit_v  = '0;
    left_v = '0;
    for (int l = 1; l <= PATTERN_MAX; l++) begin
      eq = 1'b1;
      for (int i = 0; i < l; i++) begin
        eq = eq && (win_new[l-1-i] == pattern_i[i]);
      end
      hit_v[l]  = eq && (seen_new >= SW'(l));
      left_v[l] = (seen_new == SW'(l)) || !wword_q[l-1];
    end
  end

  assign hit       = hit_v[len_eff];
  assign left_open = left_v[len_eff];

  // Pending right-side check completes regardless of the current mode
  assign found_step = found_q || (pend_q && !item_i.is_word) ||
                      (hit && ((match_mode_i == wwkm_pkg::MODE_SUBSTRING) ||
                               (left_open && item_i.last_byte)));
  assign pend_step  = hit && (match_mode_i == wwkm_pkg::MODE_WHOLE_WORD) &&
                      left_open && !item_i.last_byte;

  always_comb begin
    seen_d      = seen_q;
    pend_d      = pend_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && out_stall_i;
    matched_d   = matched_q;
    if (pop) begin
      if (item_i.last_byte) begin
        out_valid_d = 1'b1;
        matched_d   = found_step;
        seen_d      = '0;
        pend_d      = 1'b0;
        found_d     = 1'b0;
      end else begin
        seen_d  = seen_new;
        pend_d  = pend_step;
        found_d = found_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Window contents are gated by seen_q, so they need no reset
  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
    if (pop) begin
      win_q      <= win_new;
      wword_q[0] <= item_i.is_word;
      for (int k = 1; k < PATTERN_MAX; k++) begin
        wword_q[k] <= wword_q[k-1];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

endmodule

>>> hdl/whole_word_keyword_matcher_unit.sv
// ----------------------------------------------------------------------------
// whole_word_keyword_matcher_unit
// Case-insensitive keyword matcher over a byte stream, whole-word or
// substring, one verdict per message.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  --------  ---------  --------------------  -------------------------------
//  in        sink       in_valid_i/in_stall_o  text_byte_i[7:0], last_byte_i
//  out       source     out_valid_o/out_stall_i matched_o
//  cfg       sink       cfg_we_i               cfg_index_i[1:0], cfg_data_i[63:0]
//
//  Throughput: one text byte per cycle while nothing stalls. The matcher
//  compares the whole window against every candidate pattern length
//  combinationally, so that comparator bank sets the pace.
//  Verdict path: a message's verdict appears on out_valid_o once its last
//  byte has passed the input register, then the queue, into the result register.
//  Stalls: a stalled result blocks the next message's last byte and all behind it;
//  earlier bytes keep flowing into the two-entry queue and the window.
//  Reset (rst_ni, async, low): clears handshake state, message state and
//  all configuration registers.
//
module whole_word_keyword_matcher_unit #(
  parameter int unsigned PATTERN_MAX = wwkm_pkg::PATTERN_MAX_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // text in
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         text_byte_i,
  input  logic                               last_byte_i,
  // verdict out
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               matched_o,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [wwkm_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [wwkm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  // Pattern is kept already lowercased; only the bytes the window can use
  logic [PATTERN_MAX-1:0][7:0]          pattern_q, pattern_d;
  logic [wwkm_pkg::LEN_REG_W-1:0]       length_q, length_d;
  logic                                 mode_q, mode_d;

  logic            push_valid, push_stall;
  wwkm_pkg::item_t push_item;
  logic            pop_valid, pop;
  wwkm_pkg::item_t pop_item;

  always_comb begin
    pattern_d = pattern_q;
    length_d  = length_q;
    mode_d    = mode_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        wwkm_pkg::REG_PATTERN_BYTES: begin
          for (int i = 0; i < PATTERN_MAX; i++) begin
            pattern_d[i] = wwkm_pkg::fold_case(cfg_data_i[8*i +: 8]);
          end
        end
        wwkm_pkg::REG_PATTERN_LENGTH: length_d = cfg_data_i[wwkm_pkg::LEN_REG_W-1:0];
        wwkm_pkg::REG_MATCH_MODE:     mode_d   = cfg_data_i[0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      length_q  <= '0;
      mode_q    <= wwkm_pkg::MODE_WHOLE_WORD;
    end else begin
      pattern_q <= pattern_d;
      length_q  <= length_d;
      mode_q    <= mode_d;
    end
  end

  // Front: accept and classify
  wwkm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_byte_i  (text_byte_i),
    .last_byte_i  (last_byte_i),
    .push_valid_o (push_valid),
    .push_stall_i (push_stall),
    .push_item_o  (push_item)
  );

  // Decoupling queue
  wwkm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_stall_o (push_stall),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_item_o   (pop_item)
  );

  // Back: window match and verdict
  wwkm_back #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (pop_valid),
    .item_i           (pop_item),
    .item_pop_o       (pop),
    .pattern_i        (pattern_q),
    .pattern_length_i (length_q),
    .match_mode_i     (mode_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .matched_o        (matched_o)
  );

endmodule
